// ===== src/point_light_vertex_shade_top_macros.svh =====
// ----------------------------------------------------------------------------
// point_light_vertex_shade_top_macros
// Assertion helpers for the point light shading block.
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_VERTEX_SHADE_TOP_MACROS_SVH
`define POINT_LIGHT_VERTEX_SHADE_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define PLVS_ASSERT_NOW(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("plvs assertion failed");

// Next-cycle implication under reset.
`define PLVS_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("plvs assertion failed");

`endif

// ===== src/plvs_pkg.sv =====
// ----------------------------------------------------------------------------
// plvs_pkg
// Shared types and constants of the point light shading pipeline.
// ----------------------------------------------------------------------------
package plvs_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Deltas are kept to 16 bits (wider ones are flagged far), so dx^2 + 4*dy^2 fits in 35 bits.
    localparam int DELTA_W    = 16;
    localparam int SQ_W       = 36;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIST_W     = 18;
    localparam int PROD_W     = 24;
    localparam int NUM_W      = 25;
    localparam int QUOT_W     = 8;
    localparam int RGB_W      = 24;

    localparam logic [RGB_W-1:0] LIGHT_RGB_RST   = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] AMBIENT_RGB_RST = 24'h000000;

    typedef enum logic [2:0] {
        REG_LIGHT_ENABLED  = 3'd0,
        REG_ISOMETRIC_MODE = 3'd1,
        REG_LIGHT_X        = 3'd2,
        REG_LIGHT_Y        = 3'd3,
        REG_LIGHT_RADIUS   = 3'd4,
        REG_LIGHT_RGB      = 3'd5,
        REG_AMBIENT_RGB    = 3'd6
    } plvs_reg_t;

    // Side information that rides along with each item.
    typedef struct packed {
        logic             far;
        logic [RGB_W-1:0] vertex_rgb;  // red 23:16, green 15:8, blue 7:0
    } plvs_side_t;

endpackage

// ===== src/point_light_vertex_shade_top.sv =====
// ----------------------------------------------------------------------------
// point_light_vertex_shade_top
// Point light shading of a vertex stream with linear falloff.
// ----------------------------------------------------------------------------
// One item is accepted per clock while s_tready is high; its result is presented
// on m_tvalid after passing the 3-stage distance front end, the 18-stage square
// root of dx^2 + dy^2 (dx^2 + 4*dy^2 in isometric mode), the 11-stage shading
// unit with its 8-stage divider for the falloff, and the output register.
// The pipeline stalls as one; an output register plus a one-entry skid keeps
// s_tready a plain register, so a waiting result does not block the next
// transfer. Write configuration only while no item is in flight.
module point_light_vertex_shade_top #(
    parameter int COORD_WIDTH = plvs_pkg::COORD_WIDTH_DEF,
    localparam int CFG_W = (COORD_WIDTH > 24) ? COORD_WIDTH : 24,
    localparam int S_W   = ((2 * COORD_WIDTH + 24 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [2:0]                      cfg_addr,
    input  logic [CFG_W-1:0]                cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, vertex_red, vertex_green, vertex_blue, zero fill
    input  logic [S_W-1:0]                  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // shaded_red, shaded_green, shaded_blue
    output logic [23:0]                     m_tdata,
    // inside_light
    output logic                            m_tuser
);

    `include "point_light_vertex_shade_top_macros.svh"

    logic                         light_enabled_reg, isometric_mode_reg;
    logic signed [COORD_WIDTH-1:0] light_x_reg, light_y_reg;
    logic [15:0]                  light_radius_reg;
    logic [plvs_pkg::RGB_W-1:0]   light_rgb_reg, ambient_rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_enabled_reg  <= 1'b1;
            isometric_mode_reg <= 1'b0;
            light_x_reg        <= '0;
            light_y_reg        <= '0;
            light_radius_reg   <= '0;
            light_rgb_reg      <= plvs_pkg::LIGHT_RGB_RST;
            ambient_rgb_reg    <= plvs_pkg::AMBIENT_RGB_RST;
        end else if (cfg_wr_en) begin
            case (plvs_pkg::plvs_reg_t'(cfg_addr))
                plvs_pkg::REG_LIGHT_ENABLED:  light_enabled_reg  <= cfg_wdata[0];
                plvs_pkg::REG_ISOMETRIC_MODE: isometric_mode_reg <= cfg_wdata[0];
                plvs_pkg::REG_LIGHT_X:        light_x_reg <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
                plvs_pkg::REG_LIGHT_Y:        light_y_reg <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
                plvs_pkg::REG_LIGHT_RADIUS:   light_radius_reg <= cfg_wdata[15:0];
                plvs_pkg::REG_LIGHT_RGB:      light_rgb_reg    <= cfg_wdata[23:0];
                plvs_pkg::REG_AMBIENT_RGB:    ambient_rgb_reg  <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    logic                         ce;
    logic                         skid_valid_reg;
    logic [23:0]                  skid_data_reg;
    logic                         skid_lit_reg;
    logic                         m_valid_reg;
    logic [23:0]                  m_data_reg;
    logic                         m_lit_reg;

    logic                         f_valid, q_valid, p_valid, p_lit;
    logic [plvs_pkg::SQ_W-1:0]    f_sq;
    plvs_pkg::plvs_side_t         f_side, q_side;
    logic [plvs_pkg::DIST_W-1:0]  q_dist;
    logic [plvs_pkg::RGB_W-1:0]   p_rgb;
    logic [23:0]                  p_data;
    logic [23:0]                  amb_data;
    logic                         light_on;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // s_tdata carries red lowest; the color word inside holds red on top.
    plvs_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ce            (ce),
        .in_valid      (s_tvalid),
        .point_x       ($signed(s_tdata[COORD_WIDTH-1:0])),
        .point_y       ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .vertex_rgb    ({s_tdata[2*COORD_WIDTH +: 8], s_tdata[2*COORD_WIDTH+8 +: 8],
                         s_tdata[2*COORD_WIDTH+16 +: 8]}),
        .light_x       (light_x_reg),
        .light_y       (light_y_reg),
        .isometric_mode(isometric_mode_reg),
        .out_valid     (f_valid),
        .out_sq        (f_sq),
        .out_side      (f_side)
    );

    plvs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (f_valid),
        .in_sq    (f_sq),
        .in_side  (f_side),
        .out_valid(q_valid),
        .out_dist (q_dist),
        .out_side (q_side)
    );

    plvs_shade u_shade (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ce           (ce),
        .in_valid     (q_valid),
        .in_dist      (q_dist),
        .in_side      (q_side),
        .light_enabled(light_enabled_reg),
        .light_radius (light_radius_reg),
        .light_rgb    (light_rgb_reg),
        .ambient_rgb  (ambient_rgb_reg),
        .out_valid    (p_valid),
        .out_rgb      (p_rgb),
        .out_lit      (p_lit)
    );

    // m_tdata carries red lowest while the color word holds red on top.
    assign p_data = {p_rgb[7:0], p_rgb[15:8], p_rgb[23:16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= p_valid;
            end
        end else if (ce && p_valid) begin
            // output held: park the transfer in the skid
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_lit_reg  <= skid_lit_reg;
            end else begin
                m_data_reg <= p_data;
                m_lit_reg  <= p_lit;
            end
        end
        if (ce) begin
            skid_data_reg <= p_data;
            skid_lit_reg  <= p_lit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_lit_reg;

    assign amb_data = {ambient_rgb_reg[7:0], ambient_rgb_reg[15:8], ambient_rgb_reg[23:16]};
    assign light_on = light_enabled_reg && (light_radius_reg != 16'd0);

    `PLVS_ASSERT_NOW(a_skid_implies_out, aclk, aresetn, skid_valid_reg, m_valid_reg)
    `PLVS_ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg)
    `PLVS_ASSERT_NOW(a_unlit_ambient, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == amb_data)
    `PLVS_ASSERT_NOW(a_lit_needs_light, aclk, aresetn, m_tvalid && m_tuser, light_on)

endmodule

// ===== src/plvs_front.sv =====
// ----------------------------------------------------------------------------
// plvs_front
// Distance front end: absolute deltas, squares and the weighted sum.
// ----------------------------------------------------------------------------
module plvs_front #(
    parameter int COORD_WIDTH = plvs_pkg::COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [COORD_WIDTH-1:0]   point_x,
    input  logic signed [COORD_WIDTH-1:0]   point_y,
    input  logic [plvs_pkg::RGB_W-1:0]      vertex_rgb,
    input  logic signed [COORD_WIDTH-1:0]   light_x,
    input  logic signed [COORD_WIDTH-1:0]   light_y,
    input  logic                            isometric_mode,
    output logic                            out_valid,
    output logic [plvs_pkg::SQ_W-1:0]       out_sq,
    output plvs_pkg::plvs_side_t            out_side
);

    localparam int MW = (COORD_WIDTH + 1 > plvs_pkg::DELTA_W) ? COORD_WIDTH + 1
                                                              : plvs_pkg::DELTA_W;

    logic signed [COORD_WIDTH:0] ddx, ddy;
    logic [COORD_WIDTH:0]        mag_x, mag_y;
    logic [MW-1:0]               ext_x, ext_y;

    logic [2:0]                              v_reg;
    logic [plvs_pkg::DELTA_W-1:0]            dx_reg, dy_reg;
    logic [2*plvs_pkg::DELTA_W-1:0]          dxx_reg, dyy_reg;
    logic [plvs_pkg::SQ_W-1:0]               sq_reg;
    plvs_pkg::plvs_side_t                    side1_reg, side2_reg, side3_reg;

    assign ddx   = {point_x[COORD_WIDTH-1], point_x} - {light_x[COORD_WIDTH-1], light_x};
    assign ddy   = {point_y[COORD_WIDTH-1], point_y} - {light_y[COORD_WIDTH-1], light_y};
    assign mag_x = ddx[COORD_WIDTH] ? $unsigned(-ddx) : $unsigned(ddx);
    assign mag_y = ddy[COORD_WIDTH] ? $unsigned(-ddy) : $unsigned(ddy);
    assign ext_x = MW'(mag_x);
    assign ext_y = MW'(mag_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg               <= ext_x[plvs_pkg::DELTA_W-1:0];
            dy_reg               <= ext_y[plvs_pkg::DELTA_W-1:0];
            side1_reg.far        <= (|(ext_x >> plvs_pkg::DELTA_W)) ||
                                    (|(ext_y >> plvs_pkg::DELTA_W));
            side1_reg.vertex_rgb <= vertex_rgb;
            dxx_reg              <= dx_reg * dx_reg;
            dyy_reg              <= dy_reg * dy_reg;
            side2_reg            <= side1_reg;
            // vertical term counts four times in isometric mode
            sq_reg               <= plvs_pkg::SQ_W'(dxx_reg) +
                                    (isometric_mode ? plvs_pkg::SQ_W'({dyy_reg, 2'b00})
                                                    : plvs_pkg::SQ_W'(dyy_reg));
            side3_reg            <= side2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_sq    = sq_reg;
    assign out_side  = side3_reg;

endmodule

// ===== src/plvs_sqrt.sv =====
// ----------------------------------------------------------------------------
// plvs_sqrt
// Pipelined integer square root, rounded down, one result bit per stage.
// ----------------------------------------------------------------------------
module plvs_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [plvs_pkg::SQ_W-1:0]    in_sq,
    input  plvs_pkg::plvs_side_t         in_side,
    output logic                         out_valid,
    output logic [plvs_pkg::DIST_W-1:0]  out_dist,
    output plvs_pkg::plvs_side_t         out_side
);

    localparam int RW = plvs_pkg::SQ_W;
    localparam int N  = plvs_pkg::SQRT_STEPS;

    logic [N-1:0]         v_reg;
    logic [RW-1:0]        n_reg   [N];
    logic [RW-1:0]        res_reg [N];
    plvs_pkg::plvs_side_t side_reg [N];

    for (genvar j = 0; j < N; j++) begin : g_step
        localparam int BP = RW - 2 - 2 * j;
        logic [RW-1:0]        n_in, r_in, trial;
        logic                 v_in;
        plvs_pkg::plvs_side_t s_in;

        if (j == 0) begin : g_first
            assign n_in = in_sq;
            assign r_in = '0;
            assign v_in = in_valid;
            assign s_in = in_side;
        end else begin : g_next
            assign n_in = n_reg[j-1];
            assign r_in = res_reg[j-1];
            assign v_in = v_reg[j-1];
            assign s_in = side_reg[j-1];
        end

        assign trial = r_in + (RW'(1) << BP);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (ce) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (n_in >= trial) begin
                    n_reg[j]   <= n_in - trial;
                    res_reg[j] <= (r_in >> 1) + (RW'(1) << BP);
                end else begin
                    n_reg[j]   <= n_in;
                    res_reg[j] <= r_in >> 1;
                end
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_dist  = res_reg[N-1][plvs_pkg::DIST_W-1:0];
    assign out_side  = side_reg[N-1];

endmodule

// ===== src/plvs_shade.sv =====
// ----------------------------------------------------------------------------
// plvs_shade
// Lit test, falloff product, pipelined ceiling division and channel mix.
// ----------------------------------------------------------------------------
module plvs_shade (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [plvs_pkg::DIST_W-1:0]  in_dist,
    input  plvs_pkg::plvs_side_t         in_side,
    input  logic                         light_enabled,
    input  logic [15:0]                  light_radius,
    input  logic [plvs_pkg::RGB_W-1:0]   light_rgb,
    input  logic [plvs_pkg::RGB_W-1:0]   ambient_rgb,
    output logic                         out_valid,
    output logic [plvs_pkg::RGB_W-1:0]   out_rgb,
    output logic                         out_lit
);

    localparam int QW = plvs_pkg::QUOT_W;
    localparam int NW = plvs_pkg::NUM_W;
    localparam int D  = QW;
    localparam int S  = D + 3;

    logic [7:0] lc [3];
    logic [7:0] diff [3];

    logic [S-1:0]              v_reg;
    logic [S-2:0]              lit_reg;
    logic [plvs_pkg::RGB_W-1:0] vrgb_reg [S-1];
    logic [plvs_pkg::PROD_W-1:0] prod_reg [3];
    logic [NW-1:0]             rem_reg [D+1][3];
    logic [QW-1:0]             q_reg   [D][3];
    logic [plvs_pkg::RGB_W-1:0] rgb_reg;
    logic [plvs_pkg::RGB_W-1:0] rgb_next;
    logic                      lit_p;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lc[k]   = light_rgb[8*k +: 8];
            diff[k] = (light_rgb[8*k +: 8] >= ambient_rgb[8*k +: 8])
                      ? light_rgb[8*k +: 8] - ambient_rgb[8*k +: 8]
                      : ambient_rgb[8*k +: 8] - light_rgb[8*k +: 8];
        end
    end

    assign lit_p = light_enabled && (light_radius != 16'd0) && !in_side.far &&
                   (in_dist <= plvs_pkg::DIST_W'(light_radius));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[S-2:0], in_valid};
        end
    end

    // Stage 0 product, stage 1 numerator, stages 2..D+1 quotient bits.
    always_ff @(posedge aclk) begin
        if (ce) begin
            lit_reg     <= {lit_reg[S-3:0], lit_p};
            vrgb_reg[0] <= in_side.vertex_rgb;
            for (int s = 1; s < S - 1; s++) begin
                vrgb_reg[s] <= vrgb_reg[s-1];
            end
            for (int k = 0; k < 3; k++) begin
                prod_reg[k]   <= in_dist[15:0] * diff[k];
                // round the quotient up
                rem_reg[0][k] <= NW'(prod_reg[k]) + NW'(light_radius) - NW'(1);
            end
        end
    end

    for (genvar d = 0; d < D; d++) begin : g_div
        localparam int BI = QW - 1 - d;
        logic [NW-1:0] dv;
        assign dv = NW'(light_radius) << BI;

        always_ff @(posedge aclk) begin
            if (ce) begin
                for (int k = 0; k < 3; k++) begin
                    if (rem_reg[d][k] >= dv) begin
                        rem_reg[d+1][k] <= rem_reg[d][k] - dv;
                        q_reg[d][k]     <= ((d == 0) ? '0 : q_reg[(d == 0) ? 0 : d-1][k]) |
                                           (QW'(1) << BI);
                    end else begin
                        rem_reg[d+1][k] <= rem_reg[d][k];
                        q_reg[d][k]     <= (d == 0) ? '0 : q_reg[(d == 0) ? 0 : d-1][k];
                    end
                end
            end
        end
    end

    always_comb begin
        logic [7:0] fall, val, vc;
        rgb_next = ambient_rgb;
        for (int k = 0; k < 3; k++) begin
            fall = q_reg[D-1][k];
            vc   = vrgb_reg[S-2][8*k +: 8];
            val  = (fall >= lc[k]) ? 8'd0 : lc[k] - fall;
            if (lit_reg[S-2]) begin
                rgb_next[8*k +: 8] = (val < vc) ? vc : val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rgb_reg <= rgb_next;
        end
    end

    logic lit_out_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            lit_out_reg <= lit_reg[S-2];
        end
    end

    assign out_valid = v_reg[S-1];
    assign out_rgb   = rgb_reg;
    assign out_lit   = lit_out_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point light vertex shading pipeline.
// A behavioral model of the light predicts each result as its item is
// accepted. Each output transfer is then checked in order against that
// prediction. Directed cases cover zero radius, disabled light, isometric
// distance, channel clamping and coordinate extremes. Random phases follow
// with randomized light settings and varying back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int LATENCY   = 33;
    localparam int MAX_CYCLE = 400000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
    } shade_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // light state mirror
    logic        mir_enabled;
    logic        mir_iso;
    logic [15:0] mir_lx;
    logic [15:0] mir_ly;
    logic [15:0] mir_radius;
    logic [23:0] mir_light;
    logic [23:0] mir_ambient;

    shade_t      shade_queue[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int          point_count = 0;
    int          shade_count = 0;
    int          lit_count = 0;
    longint      cycle_count = 0;

    point_light_vertex_shade_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt_floor(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] fade_channel(logic [7:0] lc, logic [7:0] bc,
                                                logic [7:0] vc, logic [63:0] dist_val);
        logic [63:0] diff;
        logic [63:0] fall;
        logic [63:0] val;
        diff = (lc >= bc) ? 64'(lc - bc) : 64'(bc - lc);
        fall = (dist_val * diff + 64'(mir_radius) - 64'd1) / 64'(mir_radius);
        val  = (fall >= 64'(lc)) ? 64'd0 : 64'(lc) - fall;
        return (val < 64'(vc)) ? vc : val[7:0];
    endfunction

    function automatic shade_t shade_point(logic [15:0] px, logic [15:0] py,
                                           logic [23:0] vrgb);
        shade_t      r;
        longint      dxs;
        longint      dys;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dist_val;
        dxs  = longint'($signed(px)) - longint'($signed(mir_lx));
        dys  = longint'($signed(py)) - longint'($signed(mir_ly));
        dx   = (dxs < 0) ? -dxs : dxs;
        dy   = (dys < 0) ? -dys : dys;
        r.lit = 1'b0;
        dist_val = '0;
        if (mir_enabled && mir_radius != 0 && dx <= 64'hFFFF && dy <= 64'hFFFF) begin
            dist_val = isqrt_floor(dx * dx + (mir_iso ? 64'd4 : 64'd1) * dy * dy);
            r.lit    = (dist_val <= 64'(mir_radius));
        end
        if (r.lit) begin
            r.red   = fade_channel(mir_light[23:16], mir_ambient[23:16], vrgb[23:16], dist_val);
            r.green = fade_channel(mir_light[15:8], mir_ambient[15:8], vrgb[15:8], dist_val);
            r.blue  = fade_channel(mir_light[7:0], mir_ambient[7:0], vrgb[7:0], dist_val);
        end else begin
            r.red   = mir_ambient[23:16];
            r.green = mir_ambient[15:8];
            r.blue  = mir_ambient[7:0];
        end
        return r;
    endfunction

    task automatic write_reg(plvs_pkg::plvs_reg_t idx, logic [23:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            plvs_pkg::REG_LIGHT_ENABLED:  mir_enabled = val[0];
            plvs_pkg::REG_ISOMETRIC_MODE: mir_iso = val[0];
            plvs_pkg::REG_LIGHT_X:        mir_lx = val[15:0];
            plvs_pkg::REG_LIGHT_Y:        mir_ly = val[15:0];
            plvs_pkg::REG_LIGHT_RADIUS:   mir_radius = val[15:0];
            plvs_pkg::REG_LIGHT_RGB:      mir_light = val;
            plvs_pkg::REG_AMBIENT_RGB:    mir_ambient = val;
            default: ;
        endcase
    endtask

    task automatic set_light(logic en, logic iso, logic [15:0] lx, logic [15:0] ly,
                             logic [15:0] rad, logic [23:0] lrgb, logic [23:0] amb);
        write_reg(plvs_pkg::REG_LIGHT_ENABLED, {23'd0, en});
        write_reg(plvs_pkg::REG_ISOMETRIC_MODE, {23'd0, iso});
        write_reg(plvs_pkg::REG_LIGHT_X, {8'd0, lx});
        write_reg(plvs_pkg::REG_LIGHT_Y, {8'd0, ly});
        write_reg(plvs_pkg::REG_LIGHT_RADIUS, {8'd0, rad});
        write_reg(plvs_pkg::REG_LIGHT_RGB, lrgb);
        write_reg(plvs_pkg::REG_AMBIENT_RGB, amb);
    endtask

    // Hold the item until the transfer; s_tready is sampled at the rising edge.
    // Valid stays high into the next item unless an idle gap or wait_drain drops it.
    task automatic send_point(logic [15:0] px, logic [15:0] py, logic [23:0] vrgb);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vrgb[7:0], vrgb[15:8], vrgb[23:16], py, px};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        shade_queue.push_back(shade_point(px, py, vrgb));
        point_count++;
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (shade_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    // Check each output transfer at the rising edge where it happens.
    always @(posedge aclk) begin
        shade_t exp_s;
        if (aresetn && m_tvalid && m_tready) begin
            shade_count++;
            if (shade_queue.size() == 0) begin
                $display("%0t: unexpected result data=%h lit=%b", $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_s = shade_queue.pop_front();
                if (exp_s.lit) lit_count++;
                if (m_tdata !== {exp_s.blue, exp_s.green, exp_s.red} ||
                    m_tuser !== exp_s.lit) begin
                    $display("%0t: mismatch expected rgb=%h/%h/%h lit=%b actual rgb=%h/%h/%h lit=%b",
                             $time, exp_s.red, exp_s.green, exp_s.blue, exp_s.lit,
                             m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_defaults();
        mir_enabled = 1'b1; mir_iso = 1'b0; mir_lx = '0; mir_ly = '0;
        mir_radius = '0; mir_light = plvs_pkg::LIGHT_RGB_RST;
        mir_ambient = plvs_pkg::AMBIENT_RGB_RST;
        send_point(16'd0, 16'd0, 24'h123456);
        send_point(16'h8000, 16'h7FFF, 24'hFFFFFF);
        wait_drain();
    endtask

    task automatic test_directed();
        set_light(1'b1, 1'b0, 16'd0, 16'd0, 16'd100, 24'hFF8040, 24'h102030);
        send_point(16'd0, 16'd0, 24'h000000);
        send_point(16'd60, 16'd80, 24'h000000);
        send_point(16'd61, 16'd80, 24'h000000);
        send_point(16'hFFC4, 16'hFFB0, 24'hFFFFFF);
        send_point(16'd30, 16'd0, 24'h7F7F7F);
        wait_drain();
        // clamp: dark light over bright base drives channels below zero
        set_light(1'b1, 1'b0, 16'd0, 16'd0, 16'd10, 24'h0A0A0A, 24'hFFFFFF);
        send_point(16'd9, 16'd0, 24'h000000);
        send_point(16'd10, 16'd0, 24'h010203);
        wait_drain();
        write_reg(plvs_pkg::REG_ISOMETRIC_MODE, 24'd1);
        send_point(16'd0, 16'd5, 24'h000000);
        send_point(16'd0, 16'd6, 24'h000000);
        send_point(16'd6, 16'd3, 24'h000000);
        wait_drain();
        write_reg(plvs_pkg::REG_LIGHT_ENABLED, 24'd0);
        send_point(16'd0, 16'd0, 24'h000000);
        wait_drain();
        // extremes: light at one corner, points at all four corners
        set_light(1'b1, 1'b0, 16'h8000, 16'h8000, 16'hFFFF, 24'hFFFFFF, 24'h000000);
        send_point(16'h7FFF, 16'h8000, 24'h000000);
        send_point(16'h7FFF, 16'h7FFF, 24'h000000);
        send_point(16'h8000, 16'h8000, 24'h000000);
        send_point(16'h8000, 16'h7FFF, 24'hFFFFFF);
        wait_drain();
        // unknown index must leave the light alone
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_UNUSED;
        cfg_wdata <= 24'hFFFFFF;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        send_point(16'h8010, 16'h8010, 24'h000000);
        wait_drain();
    endtask

    task automatic random_phase(int n_items, bit wide);
        logic [15:0] rad;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] px;
        logic [15:0] py;
        int          span;
        rad = wide ? 16'($urandom_range(65535)) : 16'($urandom_range(1, 400));
        if ($urandom_range(9) == 0) rad = '0;
        lx = 16'($urandom); ly = 16'($urandom);
        set_light($urandom_range(7) != 0, 1'($urandom_range(1)), lx, ly, rad,
                  24'($urandom), 24'($urandom));
        span = (rad == 0) ? 100 : int'(rad) + int'(rad) / 4 + 2;
        repeat (n_items) begin
            if ($urandom_range(4) == 0) begin
                px = 16'($urandom); py = 16'($urandom);
            end else begin
                px = lx + 16'($urandom_range(2 * span) - span);
                py = ly + 16'($urandom_range(2 * span) - span);
            end
            send_point(px, py, 24'($urandom));
        end
        wait_drain();
    endtask

    task automatic test_random();
        int mode;
        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct  = (mode == 0) ? 16 : (mode == 1) ? 60 : 0;
            recv_stall_pct = (mode == 0) ? 60 : (mode == 1) ? 16 : 0;
            random_phase(150, 1'b0);
            random_phase(150, 1'b0);
            random_phase(100, 1'b1);
            random_phase(80, 1'b0);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random();
        $display("%0d points shaded, %0d results checked, %0d lit",
                 point_count, shade_count, lit_count);
        $display("covered circular and isometric distance, clamping, extremes, stalls");
        if (error_count == 0 && shade_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
